/* hdl/azimuth_track_association_assert.svh */
// assertion macros shared by the azimuth track association modules
`ifndef AZIMUTH_TRACK_ASSOCIATION_ASSERT_SVH
`define AZIMUTH_TRACK_ASSOCIATION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ATA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ATA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ata_pkg.sv */
// shared constants, types and codes for the azimuth track association block
package ata_pkg;

   localparam int TRACK_SLOTS = 16;
   localparam int SLOT_IDX_W  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

   localparam int STAMP_W  = 32;
   localparam int AZ_W     = 16;
   localparam int ANGLE_W  = 15;
   localparam int DIST_W   = 14;
   localparam int ID_W     = 32;
   localparam int GATE_W   = 14;
   localparam int AGE_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(23040);
   localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(11520);

   localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(1280);
   localparam logic [AGE_W-1:0]  AGE_RESET  = AGE_W'(2000);

   typedef enum logic [STATUS_W-1:0] {
      ST_MATCH = 2'd0,
      ST_NEW   = 2'd1,
      ST_MONO  = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GATE_ANGLE = 2'd0,
      CSR_MAX_AGE    = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } stat_type;

endpackage

/* hdl/ata_ctrl.sv */
// sequencer: accept, slot walk, commit
`include "azimuth_track_association_assert.svh"

module ata_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output ata_pkg::cmd_type  cmd,
   input  ata_pkg::stat_type stat
);
   import ata_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `ATA_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `ATA_ASSERT_NEXT(a_commit_frees, clock, reset, cmd.commit, !busy, "busy held after commit")

endmodule

/* hdl/ata_dp.sv */
// datapath: config registers, track table, slot walk and result registers
`include "azimuth_track_association_assert.svh"

module ata_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ata_pkg::cmd_type                      cmd,
   output ata_pkg::stat_type                     stat,
   input  logic [ata_pkg::STAMP_W-1:0]           req_stamp_ms,
   input  logic                                  req_angle_valid,
   input  logic signed [ata_pkg::AZ_W-1:0]       req_azimuth,
   output logic                                  rsp_valid,
   output logic [ata_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ata_pkg::ID_W-1:0]              rsp_track_number,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ata_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ata_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import ata_pkg::*;

   localparam logic [17:0] OFS_TWO   = 18'd46080;
   localparam logic [17:0] TURN_ONE  = 18'd23040;
   localparam logic [17:0] TURN_TWO  = 18'd46080;
   localparam logic [17:0] TURN_THREE = 18'd69120;
   localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(TRACK_SLOTS - 1);

   // configuration
   logic [GATE_W-1:0] gate_ff;
   logic [AGE_W-1:0]  max_age_ff;

   // track table
   logic                 slot_live_ff  [TRACK_SLOTS];
   logic [ANGLE_W-1:0]   slot_angle_ff [TRACK_SLOTS];
   logic [STAMP_W-1:0]   slot_last_ff  [TRACK_SLOTS];
   logic [ID_W-1:0]      slot_id_ff    [TRACK_SLOTS];
   logic [ID_W-1:0]      id_counter_ff;

   // item under work
   logic [STAMP_W-1:0]    stamp_ff;
   logic                  angle_valid_ff;
   logic [ANGLE_W-1:0]    az_ff;
   logic [SLOT_IDX_W-1:0] idx_ff;

   // walk results
   logic                  best_found_ff;
   logic [SLOT_IDX_W-1:0] best_idx_ff;
   logic [DIST_W-1:0]     best_d_ff;
   logic [ID_W-1:0]       best_id_ff;
   logic                  free_found_ff;
   logic [SLOT_IDX_W-1:0] free_idx_ff;

   // results
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [ID_W-1:0]     rsp_number_ff;

   logic [17:0]        wrap_sum;
   logic [17:0]        wrap_red;
   logic [ANGLE_W-1:0] az_in;

   logic [STAMP_W-1:0] age;
   logic               expire;
   logic               live_now;
   logic [ANGLE_W-1:0] raw_d;
   logic [ANGLE_W-1:0] fold_d;
   logic [DIST_W-1:0]  slot_dist;
   logic               better;
   logic               is_match;
   logic               do_alloc;
   logic               all_live;

   // azimuth wrap into one turn: bias by two turns, then strip whole turns
   always_comb begin
      wrap_sum = {{2{req_azimuth[AZ_W-1]}}, req_azimuth} + OFS_TWO;
      if (wrap_sum >= TURN_THREE) begin
         wrap_red = wrap_sum - TURN_THREE;
      end else if (wrap_sum >= TURN_TWO) begin
         wrap_red = wrap_sum - TURN_TWO;
      end else if (wrap_sum >= TURN_ONE) begin
         wrap_red = wrap_sum - TURN_ONE;
      end else begin
         wrap_red = wrap_sum;
      end
      az_in = wrap_red[ANGLE_W-1:0];
   end

   // per-slot test at the walk index
   always_comb begin
      age      = stamp_ff - slot_last_ff[idx_ff];
      expire   = slot_live_ff[idx_ff] && !age[STAMP_W-1] && (age > max_age_ff);
      live_now = slot_live_ff[idx_ff] && !expire;
      if (az_ff > slot_angle_ff[idx_ff]) begin
         raw_d = az_ff - slot_angle_ff[idx_ff];
      end else begin
         raw_d = slot_angle_ff[idx_ff] - az_ff;
      end
      if (raw_d > HALF_TURN) begin
         fold_d = FULL_TURN - raw_d;
      end else begin
         fold_d = raw_d;
      end
      slot_dist = fold_d[DIST_W-1:0];
      better = live_now && angle_valid_ff &&
               (!best_found_ff || (slot_dist < best_d_ff) ||
                ((slot_dist == best_d_ff) && (slot_id_ff[idx_ff] < best_id_ff)));
   end

   assign stat.scan_last = (idx_ff == LAST_IDX);

   assign is_match = best_found_ff && ({1'b0, best_d_ff} <= {1'b0, gate_ff});
   assign do_alloc = cmd.commit && angle_valid_ff && !is_match && free_found_ff;

   always_comb begin
      all_live = 1'b1;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
         all_live = all_live & slot_live_ff[i];
      end
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff    <= GATE_RESET;
         max_age_ff <= AGE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GATE_ANGLE: gate_ff    <= csr_wdata[GATE_W-1:0];
            CSR_MAX_AGE:    max_age_ff <= csr_wdata[AGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // live flags and id counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TRACK_SLOTS; i++) begin
            slot_live_ff[i] <= 1'b0;
         end
         id_counter_ff <= '0;
      end else begin
         if (cmd.scan && expire) begin
            slot_live_ff[idx_ff] <= 1'b0;
         end
         if (do_alloc) begin
            slot_live_ff[free_idx_ff] <= 1'b1;
            id_counter_ff             <= id_counter_ff + ID_W'(1);
         end
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (cmd.commit && angle_valid_ff && is_match) begin
         slot_angle_ff[best_idx_ff] <= az_ff;
         slot_last_ff[best_idx_ff]  <= stamp_ff;
      end else if (do_alloc) begin
         slot_angle_ff[free_idx_ff] <= az_ff;
         slot_last_ff[free_idx_ff]  <= stamp_ff;
         slot_id_ff[free_idx_ff]    <= id_counter_ff;
      end
   end

   // item capture and walk state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stamp_ff       <= req_stamp_ms;
         angle_valid_ff <= req_angle_valid;
         az_ff          <= az_in;
         idx_ff         <= '0;
         best_found_ff  <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.scan) begin
         if (!stat.scan_last) begin
            idx_ff <= idx_ff + SLOT_IDX_W'(1);
         end
         if (better) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= idx_ff;
            best_d_ff     <= slot_dist;
            best_id_ff    <= slot_id_ff[idx_ff];
         end
         if (!live_now && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (!angle_valid_ff) begin
            rsp_status_ff <= ST_MONO;
            rsp_number_ff <= '0;
         end else if (is_match) begin
            rsp_status_ff <= ST_MATCH;
            rsp_number_ff <= best_id_ff;
         end else if (free_found_ff) begin
            rsp_status_ff <= ST_NEW;
            rsp_number_ff <= id_counter_ff;
         end else begin
            rsp_status_ff <= ST_FULL;
            rsp_number_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_track_number = rsp_number_ff;

   `ATA_ASSERT_NEXT(a_strobe_after_commit, clock, reset, cmd.commit, rsp_valid_ff, "no strobe after commit")
   `ATA_ASSERT_SAME(a_new_bumps_id, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_NEW), id_counter_ff == rsp_number_ff + ID_W'(1), "id counter not advanced for new track")
   `ATA_ASSERT_SAME(a_full_means_full, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_FULL), all_live, "full reported with a free slot")

endmodule

/* hdl/azimuth_track_association.sv */
// top level of the azimuth track association block
// an accepted item is captured, then every track slot is walked in turn, then the item is committed,
// and the strobed result is registered from the commit state
// a new item is not accepted while one is in work (busy); the table walk goes one slot a cycle
// the next item is accepted in the cycle its result is on the rsp ports; results cannot stall
// synchronous active-high reset: table empty, id counter zero, gate 1280, max age 2000 ms
module azimuth_track_association (
   input  logic                                  clock,
   input  logic                                  reset,
   // item channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ata_pkg::STAMP_W-1:0]           req_stamp_ms,
   input  logic                                  req_angle_valid,
   input  logic signed [ata_pkg::AZ_W-1:0]       req_azimuth,
   // result channel, one-cycle strobe
   output logic                                  rsp_valid,
   output logic [ata_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ata_pkg::ID_W-1:0]              rsp_track_number,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ata_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ata_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import ata_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     start_ok;

   // the sequencer only sees a start while it is idle
   assign start_ok = start && !busy;

   // sequencer: idle -> walk all slots -> commit
   ata_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start_ok),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // config registers, table, expiry, nearest search, allocation and result registers
   ata_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_stamp_ms     (req_stamp_ms),
      .req_angle_valid  (req_angle_valid),
      .req_azimuth      (req_azimuth),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_track_number (rsp_track_number),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

/* sim/ata_checker.sv */
// checker for the azimuth track association block: predicts every result and compares it
module ata_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [ata_pkg::STAMP_W-1:0]           req_stamp_ms,
   input  logic                                  req_angle_valid,
   input  logic signed [ata_pkg::AZ_W-1:0]       req_azimuth,
   input  logic                                  rsp_valid,
   input  logic [ata_pkg::STATUS_W-1:0]          rsp_status,
   input  logic [ata_pkg::ID_W-1:0]              rsp_track_number,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [ata_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ata_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output int                                    n_errors,
   output int                                    n_pending,
   output int                                    n_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import ata_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   number;
   } association_type;

   logic                track_live  [TRACK_SLOTS];
   logic [ANGLE_W-1:0]  track_angle [TRACK_SLOTS];
   logic [STAMP_W-1:0]  track_seen  [TRACK_SLOTS];
   logic [ID_W-1:0]     track_num   [TRACK_SLOTS];
   logic [ID_W-1:0]     next_id;
   logic [GATE_W-1:0]   gate_cfg;
   logic [AGE_W-1:0]    age_cfg;

   association_type     expected_tracks [$];
   association_type     want;
   int                  errs = 0;
   int                  checked = 0;
   int                  slot;

   function automatic association_type associate_detection(
      input logic [STAMP_W-1:0]     stamp,
      input logic                   has_angle,
      input logic signed [AZ_W-1:0] raw
   );
      association_type     res;
      logic [STAMP_W-1:0]  elapsed;
      int                  az;
      int                  d;
      int                  best;
      int                  best_d;
      int                  i;
      res.status = ST_MONO;
      res.number = '0;
      // age test on the signed stamp difference
      for (i = 0; i < TRACK_SLOTS; i++) begin
         elapsed = stamp - track_seen[i];
         if (track_live[i] && longint'($signed(elapsed)) > longint'({32'd0, age_cfg}))
            track_live[i] = 1'b0;
      end
      if (!has_angle)
         return res;
      az = int'(raw) % int'(FULL_TURN);
      if (az < 0)
         az += int'(FULL_TURN);
      best = -1;
      best_d = 0;
      for (i = 0; i < TRACK_SLOTS; i++) begin
         if (track_live[i]) begin
            d = az - int'(track_angle[i]);
            if (d < 0)
               d = -d;
            if (d > int'(HALF_TURN))
               d = int'(FULL_TURN) - d;
            if (best < 0 || d < best_d || (d == best_d && track_num[i] < track_num[best])) begin
               best = i;
               best_d = d;
            end
         end
      end
      if (best >= 0 && best_d <= int'(gate_cfg)) begin
         track_angle[best] = ANGLE_W'(az);
         track_seen[best] = stamp;
         res.status = ST_MATCH;
         res.number = track_num[best];
         return res;
      end
      for (i = 0; i < TRACK_SLOTS; i++) begin
         if (!track_live[i]) begin
            track_live[i] = 1'b1;
            track_angle[i] = ANGLE_W'(az);
            track_seen[i] = stamp;
            track_num[i] = next_id;
            next_id = next_id + 1'b1;
            res.status = ST_NEW;
            res.number = track_num[i];
            return res;
         end
      end
      res.status = ST_FULL;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (slot = 0; slot < TRACK_SLOTS; slot++) begin
            track_live[slot] = 1'b0;
            track_angle[slot] = '0;
            track_seen[slot] = '0;
            track_num[slot] = '0;
         end
         next_id = '0;
         gate_cfg = GATE_RESET;
         age_cfg = AGE_RESET;
         expected_tracks.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_tracks.size() == 0) begin
               errs++;
               $display("%t ata_checker: unexpected result, status %0d track %0d",
                        $realtime, rsp_status, rsp_track_number);
            end else begin
               want = expected_tracks.pop_front();
               checked++;
               if (rsp_status !== want.status || rsp_track_number !== want.number) begin
                  errs++;
                  if (rsp_status !== want.status)
                     $display("%t ata_checker: status expected %0d actual %0d",
                              $realtime, want.status, rsp_status);
                  if (rsp_track_number !== want.number)
                     $display("%t ata_checker: track expected %0d actual %0d",
                              $realtime, want.number, rsp_track_number);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GATE_ANGLE)
               gate_cfg = csr_wdata[GATE_W-1:0];
            else if (csr_index == CSR_MAX_AGE)
               age_cfg = csr_wdata[AGE_W-1:0];
         end
         if (start && !busy)
            expected_tracks = {expected_tracks,
               associate_detection(req_stamp_ms, req_angle_valid, req_azimuth)};
      end
      n_errors <= errs;
      n_pending <= expected_tracks.size();
      n_checked <= checked;
   end

endmodule

/* sim/tb_top.sv */
// testbench top for the azimuth track association block: stimulus, run limit and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ata_pkg::*;

   // register indexes the block has no register for
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [STAMP_W-1:0]        req_stamp_ms = '0;
   logic                      req_angle_valid = 1'b0;
   logic signed [AZ_W-1:0]    req_azimuth = '0;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic [ID_W-1:0]           rsp_track_number;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int                        n_errors;
   int                        n_pending;
   int                        n_checked;

   // stimulus bookkeeping
   int                        idle_pct = 7;
   int                        sent = 0;
   int                        settings = 0;
   logic [STAMP_W-1:0]        now_ms = '0;
   int                        recent_az [$];

   azimuth_track_association u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_stamp_ms     (req_stamp_ms),
      .req_angle_valid  (req_angle_valid),
      .req_azimuth      (req_azimuth),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_track_number (rsp_track_number),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   ata_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_stamp_ms     (req_stamp_ms),
      .req_angle_valid  (req_angle_valid),
      .req_azimuth      (req_azimuth),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_track_number (rsp_track_number),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .n_errors         (n_errors),
      .n_pending        (n_pending),
      .n_checked        (n_checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // present one detection and hold it until the block takes it
   // start stays high on return so back-to-back items need no second assignment
   task automatic offer_detection(input logic [STAMP_W-1:0] stamp, input logic has_angle,
                                  input int az);
      int gap;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct)
         gap = $urandom_range(1, 40);
      // long gaps move the next start across every cycle of the slot walk
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_stamp_ms <= stamp;
      req_angle_valid <= has_angle;
      req_azimuth <= AZ_W'(az);
      // busy read right after the edge is its value at that edge
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      if (has_angle) begin
         recent_az = {recent_az, az};
         if (recent_az.size() > TRACK_SLOTS)
            void'(recent_az.pop_front());
      end
   endtask

   // one register write, valid left high for a following write
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      int gap;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] gate, input logic [CSR_DATA_W-1:0] age,
                            input logic with_spares);
      if (with_spares) begin
         // writes to unmapped indexes must leave both registers alone
         write_register(CSR_SPARE_A, $urandom);
         write_register(CSR_SPARE_B, $urandom);
      end
      write_register(CSR_GATE_ANGLE, gate);
      write_register(CSR_MAX_AGE, age);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings++;
   endtask

   // drain: no item in flight, nothing expected, then a wait no shorter than the block's latency
   task automatic settle_block();
      start <= 1'b0;
      @(posedge clock);
      while (busy || n_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // random detection: mostly a stamp moving forward and an azimuth near a recent one,
   // so matches, new tracks, ageing and a full table all come up
   task automatic random_detection(input int gate_span, input int unsigned step_max);
      int                  pick;
      int                  az;
      logic [STAMP_W-1:0]  stamp;
      pick = $urandom_range(99);
      if (pick < 3)
         stamp = $urandom;
      else if (pick < 8)
         stamp = now_ms - $urandom_range(0, 500);
      else
         stamp = now_ms + $urandom_range(0, step_max);
      // a stamp going back does not move the clock
      if (pick < 3 || pick >= 8)
         now_ms = stamp;
      pick = $urandom_range(99);
      if (pick < 65 && recent_az.size() > 0) begin
         az = recent_az[$urandom_range(0, recent_az.size() - 1)]
              + int'($urandom_range(0, 2 * gate_span + 2)) - gate_span - 1;
         // fold back into the 16-bit range, keeping the same direction
         if (az > 32767)
            az -= 23040;
         if (az < -32768)
            az += 23040;
         // same direction written one turn away
         if ($urandom_range(3) == 0) begin
            if (az + 23040 <= 32767)
               az += 23040;
            else if (az - 23040 >= -32768)
               az -= 23040;
         end
      end else begin
         az = int'($urandom_range(0, 65535)) - 32768;
      end
      offer_detection(stamp, $urandom_range(99) >= 8, az);
   endtask

   initial begin
      int                  phase;
      int                  k;
      int                  gate_span;
      int unsigned         step;
      logic [31:0]         gate;
      logic [31:0]         age;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset settings: gate 1280, max age 2000
      offer_detection(32'd0, 1'b0, 0);           // mono on an empty table
      offer_detection(32'd10, 1'b1, 1000);       // first track, id 0
      offer_detection(32'd20, 1'b1, 3000);       // too far for the gate: id 1
      offer_detection(32'd30, 1'b1, 2000);       // equal distance to both, id 0 wins
      offer_detection(32'd1500, 1'b1, 3000);     // refresh id 1
      offer_detection(32'd2031, 1'b1, 5000);     // id 0 ages out by one ms, id 2 takes slot 0
      offer_detection(32'd2040, 1'b1, 4000);     // tie: id 1 in the higher slot still wins
      offer_detection(32'd2050, 1'b1, -32768);   // most negative azimuth
      offer_detection(32'd2060, 1'b1, 32767);    // most positive azimuth
      offer_detection(32'd2070, 1'b1, -1);       // just below zero wraps to the top
      offer_detection(32'd2000, 1'b1, 23040);    // stamp earlier than last seen, match across zero

      // exact gate and no ageing: fill the table and run past full
      settle_block();
      configure(32'd0, 32'hFFFF_FFFF, 1'b0);
      for (k = 0; k < 14; k++)
         offer_detection(32'd2100 + k, 1'b1, 200 + 1100 * k);
      offer_detection(32'hFFFF_FFFF, 1'b0, -32768);  // mono at the top stamp

      // random phases, each with its own register setting
      now_ms = 32'd10000;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               gate = 32'd1280;
               age = 32'd2000;
               step = 300;
            end
            1: begin
               gate = 32'd0;
               age = 32'd0;
               step = 2;
            end
            2: begin
               // every live track within reach, nothing ever ages out
               gate = 32'd11520;
               age = 32'hFFFF_FFFF;
               step = 32'hFFFF_FFFF;
            end
            3: begin
               // upper bits dropped: gate lands at 16383
               gate = 32'hFFFF_FFFF;
               age = 32'h7FFF_FFFF;
               step = 1000;
            end
            4: begin
               // narrow gate, tracks pile up to a full table
               gate = 32'd300;
               age = 32'd5000;
               step = 400;
            end
            5: begin
               gate = $urandom_range(0, 11520);
               age = $urandom_range(0, 20000);
               step = age / 4 + 1;
            end
            6: begin
               // stamps run through the 32-bit wrap
               gate = 32'd64;
               age = 32'h8000_0000;
               step = 20;
               now_ms = 32'hFFFF_FF00;
            end
            default: begin
               gate = $urandom_range(0, 11520);
               age = $urandom;
               step = $urandom_range(1, 100000);
            end
         endcase
         gate_span = int'(gate[GATE_W-1:0]);
         // two phases back to back with no idling at all
         idle_pct = (phase == 2 || phase == 3) ? 0 : 7;
         settle_block();
         configure(gate, age, phase == 4);
         repeat (200) random_detection(gate_span, step);
      end

      settle_block();
      $display("tb_top: %0d detections over %0d register settings, %0d results compared",
               sent, settings, n_checked);
      $display("tb_top: gates from exact to past half a turn, ages from zero to 32-bit max");
      if (n_errors == 0 && n_pending == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
